@@ sv/gcpc_pkg.sv @@
package gcpc_pkg;

  localparam int unsigned NUM_POINTS = 5;
  localparam int unsigned CONC_W     = 16;
  localparam int unsigned ADC_W      = 16;
  localparam int unsigned PIDX_W     = 3;
  localparam int unsigned ERR_W      = 4;
  localparam int unsigned PADDR_W    = 3;

  // calibration modes
  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_NEG = 2'd1;
  localparam logic [1:0] MODE_BID = 2'd2;

  // input actions
  localparam logic ACT_CAL  = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // register indexes
  localparam logic REG_CAL_MODE  = 1'b0;
  localparam logic REG_DEAD_BAND = 1'b1;

  // reference points
  localparam logic [PIDX_W-1:0] PT_1     = 3'd0;
  localparam logic [PIDX_W-1:0] PT_2     = 3'd1;
  localparam logic [PIDX_W-1:0] PT_3     = 3'd2;
  localparam logic [PIDX_W-1:0] PT_4     = 3'd3;
  localparam logic [PIDX_W-1:0] PT_5     = 3'd4;
  localparam logic [PIDX_W-1:0] NO_POINT = 3'd5;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK           = 4'd0;
  localparam logic [ERR_W-1:0] ERR_POS_BELOW    = 4'd1;
  localparam logic [ERR_W-1:0] ERR_POS_BAND     = 4'd2;
  localparam logic [ERR_W-1:0] ERR_NEG_ABOVE    = 4'd3;
  localparam logic [ERR_W-1:0] ERR_NEG_BAND     = 4'd4;
  localparam logic [ERR_W-1:0] ERR_BID_BAND     = 4'd5;
  localparam logic [ERR_W-1:0] ERR_P1_ABOVE_P3  = 4'd6;
  localparam logic [ERR_W-1:0] ERR_P2_ABOVE_P3  = 4'd7;
  localparam logic [ERR_W-1:0] ERR_P2_BELOW_P1  = 4'd8;
  localparam logic [ERR_W-1:0] ERR_P4_ABOVE_P5  = 4'd9;
  localparam logic [ERR_W-1:0] ERR_P4_BELOW_P3  = 4'd10;
  localparam logic [ERR_W-1:0] ERR_P5_BELOW_P3  = 4'd11;

  typedef logic [NUM_POINTS-1:0][CONC_W-1:0] conc_tbl_t;
  typedef logic [NUM_POINTS-1:0][ADC_W-1:0]  adc_tbl_t;

  typedef struct packed {
    logic                 action;
    logic [PIDX_W-1:0]    point_index;
    logic [CONC_W-1:0]    conc_value;
    logic [ADC_W-1:0]     adc_sample;
  } in_item_t;

  typedef struct packed {
    logic                  success;
    logic [ERR_W-1:0]      error_code;
    logic [PIDX_W-1:0]     stored_point;
    logic [NUM_POINTS-1:0] save_flags;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        cal_mode;
    logic [ADC_W-1:0]  dead_band;
  } cfg_t;

  // decision of the check unit for one item
  typedef struct packed {
    logic              success;
    logic [ERR_W-1:0]  error_code;
    logic              wr_en;
    logic              set_flag;
    logic [PIDX_W-1:0] stored_point;
  } eval_t;

endpackage

@@ sv/gas_calibration_point_checker.sv @@
// Gas calibration point checker.
// Command channel: an item (action, point_index, conc_value, adc_sample) is
// taken at a clock edge where start is high and busy is low. busy stays low,
// so an item may be issued every cycle.
// Result channel: result_valid_o pulses for one cycle with result_o
// (success, error_code, stored_point, save_flags). The receiver cannot stall;
// every result must be taken in the cycle it is shown.
// Pipeline: an accepted item passes the input register, then the check and
// table write into the result register.
// Throughput: one item per cycle; the table write lands at the same edge as
// the result, so the next item already sees it.
// Configuration: APB cal_mode at 0x0, dead_band at 0x4; pready is tied high.
// The user writes them only with no item in flight; this is not enforced.
// Reset (rst_ni low, asynchronous): reference table, save flags, registers
// and both pipeline valids clear to zero.
module gas_calibration_point_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  gcpc_pkg::in_item_t           item_i,
  output logic                         result_valid_o,
  output gcpc_pkg::out_item_t          result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcpc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import gcpc_pkg::*;

  cfg_t                  cfg;
  eval_t                 ev;
  logic                  in_valid_q;
  in_item_t              in_q;
  logic                  res_valid_q;
  out_item_t             res_q, res_d;
  conc_tbl_t             ref_conc_q;
  adc_tbl_t              ref_adc_q;
  logic [NUM_POINTS-1:0] pending_q, pending_d;

  assign busy = 1'b0;

  gcpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gcpc_eval u_eval (
    .item_i     (in_q),
    .cfg_i      (cfg),
    .ref_conc_i (ref_conc_q),
    .ref_adc_i  (ref_adc_q),
    .eval_o     (ev)
  );

  always_comb begin
    pending_d = pending_q;
    if (in_valid_q && ev.set_flag) begin
      pending_d[ev.stored_point] = 1'b1;
    end
    res_d.success      = ev.success;
    res_d.error_code   = ev.error_code;
    res_d.stored_point = ev.stored_point;
    res_d.save_flags   = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      pending_q   <= '0;
      ref_conc_q  <= '0;
      ref_adc_q   <= '0;
    end else begin
      in_valid_q  <= start && !busy;
      res_valid_q <= in_valid_q;
      pending_q   <= pending_d;
      if (in_valid_q && ev.wr_en) begin
        ref_conc_q[ev.stored_point] <= in_q.conc_value;
        ref_adc_q[ev.stored_point]  <= in_q.adc_sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ sv/gcpc_cfg.sv @@
module gcpc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcpc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output gcpc_pkg::cfg_t               cfg_o
);
  import gcpc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  // word aligned: byte offset bits are ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CAL_MODE:  cfg_d.cal_mode  = pwdata[1:0];
        REG_DEAD_BAND: cfg_d.dead_band = pwdata[ADC_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAL_MODE:  prdata = {30'd0, cfg_q.cal_mode};
      REG_DEAD_BAND: prdata = {{(32-ADC_W){1'b0}}, cfg_q.dead_band};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/gcpc_eval.sv @@
module gcpc_eval (
  input  gcpc_pkg::in_item_t  item_i,
  input  gcpc_pkg::cfg_t      cfg_i,
  input  gcpc_pkg::conc_tbl_t ref_conc_i,
  input  gcpc_pkg::adc_tbl_t  ref_adc_i,
  output gcpc_pkg::eval_t     eval_o
);
  import gcpc_pkg::*;

  logic [ADC_W:0]    adc_x;
  logic [ADC_W:0]    band_x;
  logic [ADC_W:0]    zero1_x;
  logic [ADC_W:0]    zero3_x;
  logic [ADC_W-1:0]  adc;
  logic [CONC_W-1:0] conc;
  logic              in_band;
  eval_t             ev;

  assign adc     = item_i.adc_sample;
  assign conc    = item_i.conc_value;
  assign adc_x   = {1'b0, adc};
  assign band_x  = {1'b0, cfg_i.dead_band};
  assign zero1_x = {1'b0, ref_adc_i[PT_1]};
  assign zero3_x = {1'b0, ref_adc_i[PT_3]};

  // bidirectional dead band around point 3; equal counts as below
  always_comb begin
    if (adc > ref_adc_i[PT_3]) begin
      in_band = adc_x < (zero3_x + band_x);
    end else begin
      in_band = (adc_x + band_x) > zero3_x;
    end
  end

  always_comb begin
    ev              = '0;
    ev.error_code   = ERR_OK;
    ev.stored_point = NO_POINT;
    if (item_i.action == ACT_LOAD) begin
      if (item_i.point_index <= PT_5) begin
        ev.wr_en        = 1'b1;
        ev.stored_point = item_i.point_index;
      end
    end else begin
      unique case (cfg_i.cal_mode)
        MODE_POS: begin
          priority if (adc_x < zero1_x) begin
            ev.error_code = ERR_POS_BELOW;
          end else if (adc_x < (zero1_x + band_x)) begin
            ev.error_code = ERR_POS_BAND;
          end else begin
            ev.success      = 1'b1;
            ev.wr_en        = 1'b1;
            ev.set_flag     = 1'b1;
            ev.stored_point = PT_3;
          end
        end
        MODE_NEG: begin
          priority if (adc_x > zero3_x) begin
            ev.error_code = ERR_NEG_ABOVE;
          end else if ((adc_x + band_x) > zero3_x) begin
            ev.error_code = ERR_NEG_BAND;
          end else begin
            ev.success      = 1'b1;
            ev.wr_en        = 1'b1;
            ev.set_flag     = 1'b1;
            ev.stored_point = PT_1;
          end
        end
        MODE_BID: begin
          if (in_band) begin
            ev.error_code = ERR_BID_BAND;
          end else begin
            priority if (conc == ref_conc_i[PT_1]) begin
              if (adc > ref_adc_i[PT_3]) ev.error_code = ERR_P1_ABOVE_P3;
              else ev.stored_point = PT_1;
            end else if (conc < ref_conc_i[PT_3]) begin
              priority if (adc > ref_adc_i[PT_3]) ev.error_code = ERR_P2_ABOVE_P3;
              else if (adc < ref_adc_i[PT_1]) ev.error_code = ERR_P2_BELOW_P1;
              else ev.stored_point = PT_2;
            end else if (conc < ref_conc_i[PT_5]) begin
              priority if (adc > ref_adc_i[PT_5]) ev.error_code = ERR_P4_ABOVE_P5;
              else if (adc < ref_adc_i[PT_3]) ev.error_code = ERR_P4_BELOW_P3;
              else ev.stored_point = PT_4;
            end else if (conc == ref_conc_i[PT_5]) begin
              if (adc < ref_adc_i[PT_3]) ev.error_code = ERR_P5_BELOW_P3;
              else ev.stored_point = PT_5;
            end else begin
              // above point 5: passes, nothing stored
              ev.stored_point = NO_POINT;
            end
            ev.success  = (ev.error_code == ERR_OK);
            ev.wr_en    = (ev.stored_point != NO_POINT);
            ev.set_flag = ev.wr_en;
          end
        end
        default: begin
          ev.stored_point = NO_POINT;
        end
      endcase
    end
  end

  assign eval_o = ev;

endmodule

@@ tb/gcpc_result_checker.sv @@
module gcpc_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  gcpc_pkg::in_item_t           item_i,
  input  logic                         res_valid_i,
  input  gcpc_pkg::out_item_t          res_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [gcpc_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                  pwdata_i,
  output int                           fails_o,
  output int                           pending_o
);
  import gcpc_pkg::*;

  logic [CONC_W-1:0]     conc_tbl [NUM_POINTS];
  logic [ADC_W-1:0]      adc_tbl  [NUM_POINTS];
  logic [NUM_POINTS-1:0] save_flags;
  logic [1:0]            cal_mode;
  logic [ADC_W-1:0]      dead_band;
  out_item_t             expected_q [$];

  // Work out the result of one item and update the mirrored table.
  task automatic apply_item(input in_item_t it, output out_item_t res);
    logic [ADC_W:0]    adc_w;
    logic [ADC_W:0]    zero_w;
    logic [ADC_W:0]    db_w;
    logic              band;
    logic [PIDX_W-1:0] target;
    res.success      = 1'b0;
    res.error_code   = ERR_OK;
    res.stored_point = NO_POINT;
    target           = NO_POINT;
    adc_w            = {1'b0, it.adc_sample};
    db_w             = {1'b0, dead_band};
    if (it.action == ACT_LOAD) begin
      if (it.point_index < NUM_POINTS) begin
        conc_tbl[it.point_index] = it.conc_value;
        adc_tbl[it.point_index]  = it.adc_sample;
        res.stored_point         = it.point_index;
      end
    end else if (cal_mode == MODE_POS) begin
      zero_w = {1'b0, adc_tbl[PT_1]};
      if (adc_w < zero_w) res.error_code = ERR_POS_BELOW;
      else if (adc_w < zero_w + db_w) res.error_code = ERR_POS_BAND;
      else target = PT_3;
    end else if (cal_mode == MODE_NEG) begin
      zero_w = {1'b0, adc_tbl[PT_3]};
      if (adc_w > zero_w) res.error_code = ERR_NEG_ABOVE;
      else if (adc_w + db_w > zero_w) res.error_code = ERR_NEG_BAND;
      else target = PT_1;
    end else if (cal_mode == MODE_BID) begin
      zero_w = {1'b0, adc_tbl[PT_3]};
      // a reading equal to the zero point falls on the lower side
      band = (adc_w > zero_w) ? (adc_w < zero_w + db_w) : (adc_w + db_w > zero_w);
      if (band) begin
        res.error_code = ERR_BID_BAND;
      end else if (it.conc_value == conc_tbl[PT_1]) begin
        if (it.adc_sample > adc_tbl[PT_3]) res.error_code = ERR_P1_ABOVE_P3;
        else target = PT_1;
      end else if (it.conc_value < conc_tbl[PT_3]) begin
        if (it.adc_sample > adc_tbl[PT_3]) res.error_code = ERR_P2_ABOVE_P3;
        else if (it.adc_sample < adc_tbl[PT_1]) res.error_code = ERR_P2_BELOW_P1;
        else target = PT_2;
      end else if (it.conc_value < conc_tbl[PT_5]) begin
        if (it.adc_sample > adc_tbl[PT_5]) res.error_code = ERR_P4_ABOVE_P5;
        else if (it.adc_sample < adc_tbl[PT_3]) res.error_code = ERR_P4_BELOW_P3;
        else target = PT_4;
      end else if (it.conc_value == conc_tbl[PT_5]) begin
        if (it.adc_sample < adc_tbl[PT_3]) res.error_code = ERR_P5_BELOW_P3;
        else target = PT_5;
      end else begin
        // past point 5: accepted, nothing stored
        res.success = 1'b1;
      end
    end
    if (target != NO_POINT) begin
      conc_tbl[target]   = it.conc_value;
      adc_tbl[target]    = it.adc_sample;
      save_flags[target] = 1'b1;
      res.success        = 1'b1;
      res.stored_point   = target;
    end
    res.save_flags = save_flags;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        conc_tbl[i] = '0;
        adc_tbl[i]  = '0;
      end
      save_flags = '0;
      cal_mode   = MODE_POS;
      dead_band  = '0;
      expected_q.delete();
      fails_o    = 0;
      pending_o  = 0;
    end else begin
      // results first, so an item taken at this edge is never matched here
      if (res_valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding");
          fails_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("success", 16'(want.success), 16'(res_i.success));
          check_field("error_code", 16'(want.error_code), 16'(res_i.error_code));
          check_field("stored_point", 16'(want.stored_point), 16'(res_i.stored_point));
          check_field("save_flags", 16'(want.save_flags), 16'(res_i.save_flags));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_CAL_MODE:  cal_mode  = pwdata_i[1:0];
          REG_DEAD_BAND: dead_band = pwdata_i[ADC_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        apply_item(item_i, want);
        expected_q.push_back(want);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ tb/gas_calibration_point_checker_tb.sv @@
module gas_calibration_point_checker_tb;
  import gcpc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start   = 1'b0;
  logic                 busy;
  in_item_t             item    = '0;
  logic                 res_valid;
  out_item_t            res;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   fails;
  int                   pending;

  // points as last preloaded, used to aim readings at the interesting edges
  logic [CONC_W-1:0]    loaded_conc [NUM_POINTS] = '{default: '0};
  logic [ADC_W-1:0]     loaded_adc  [NUM_POINTS] = '{default: '0};
  logic [1:0]           cur_mode = MODE_POS;
  logic [ADC_W-1:0]     cur_db   = '0;
  int unsigned          idle_pct = 0;

  always #5 clk_i = ~clk_i;

  gas_calibration_point_checker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (res_valid),
    .result_o       (res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  gcpc_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .res_valid_i (res_valid),
    .res_i       (res),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  function automatic logic [15:0] clamp16(int x);
    if (x < 0) return 16'h0000;
    if (x > 65535) return 16'hFFFF;
    return x[15:0];
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] v, int span);
    return clamp16(int'(v) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [PIDX_W-1:0] pick_point();
    return PIDX_W'($urandom_range(0, NUM_POINTS - 1));
  endfunction

  function automatic in_item_t make_reading();
    in_item_t    it;
    int          zero;
    int          sgn;
    int unsigned k;
    it.action      = ACT_CAL;
    it.point_index = PIDX_W'($urandom_range(0, 7));
    k = $urandom_range(0, 9);
    if (k < 4) it.conc_value = loaded_conc[pick_point()];
    else if (k < 6) it.conc_value = nudge(loaded_conc[pick_point()], 2);
    else if (k < 9) it.conc_value = 16'($urandom_range(loaded_conc[PT_1], loaded_conc[PT_5]));
    else it.conc_value = 16'($urandom_range(0, 16'hFFFF));
    zero = (cur_mode == MODE_POS) ? int'(loaded_adc[PT_1]) : int'(loaded_adc[PT_3]);
    sgn  = $urandom_range(0, 1) ? 1 : -1;
    k = $urandom_range(0, 9);
    // hit the dead-band edges, the points, the spans between them, or anything
    if (k < 3) it.adc_sample = clamp16(zero + sgn * int'(cur_db) + int'($urandom_range(0, 2)) - 1);
    else if (k < 6) it.adc_sample = nudge(loaded_adc[pick_point()], 2);
    else if (k < 8) it.adc_sample = 16'($urandom_range(loaded_adc[pick_point()],
                                                       loaded_adc[pick_point()]));
    else it.adc_sample = 16'($urandom_range(0, 16'hFFFF));
    return it;
  endfunction

  // start stays up between back-to-back items; it only drops in rest/settle
  task automatic issue(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    if (it.action == ACT_LOAD && it.point_index < NUM_POINTS) begin
      loaded_conc[it.point_index] = it.conc_value;
      loaded_adc[it.point_index]  = it.adc_sample;
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic calibrate(input logic [15:0] conc, input logic [15:0] adc);
    issue('{action: ACT_CAL, point_index: PT_1, conc_value: conc, adc_sample: adc});
  endtask

  task automatic preload(input logic [PIDX_W-1:0] idx, input logic [15:0] conc,
                         input logic [15:0] adc);
    issue('{action: ACT_LOAD, point_index: idx, conc_value: conc, adc_sample: adc});
  endtask

  // wait until every item has its result, then let the pipe drain
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cfg(input logic [1:0] mode, input logic [15:0] db);
    settle();
    apb_write({REG_CAL_MODE, 2'b00}, {30'd0, mode});
    apb_write({REG_DEAD_BAND, 2'b00}, {16'd0, db});
    cur_mode = mode;
    cur_db   = db;
  endtask

  task automatic load_table(input bit ordered);
    logic [15:0] c [NUM_POINTS];
    logic [15:0] a [NUM_POINTS];
    c[0] = 16'($urandom_range(0, 6000));
    a[0] = 16'($urandom_range(0, 6000));
    for (int i = 1; i < NUM_POINTS; i++) begin
      c[i] = 16'(ordered ? c[i-1] + $urandom_range(1, 14000) : $urandom_range(0, 16'hFFFF));
      a[i] = 16'(ordered ? a[i-1] + $urandom_range(1, 14000) : $urandom_range(0, 16'hFFFF));
    end
    for (int i = 0; i < NUM_POINTS; i++) preload(PIDX_W'(i), c[i], a[i]);
  endtask

  initial begin
    in_item_t    it;
    int unsigned r;
    logic [1:0]  mode;
    logic [15:0] db;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // positive mode from reset values
    calibrate(16'hFFFF, 16'hFFFF);
    preload(PT_1, 16'd0, 16'd1000);
    calibrate(16'd1, 16'd999);
    set_cfg(MODE_POS, 16'd50);
    calibrate(16'd2, 16'd1049);
    calibrate(16'd3, 16'd1050);
    // preload index out of range
    preload(3'd5, 16'h0000, 16'h0000);
    preload(3'd6, 16'h5A5A, 16'hA5A5);
    preload(3'd7, 16'hFFFF, 16'hFFFF);

    set_cfg(MODE_NEG, 16'd50);
    calibrate(16'd4, 16'd1051);
    calibrate(16'd5, 16'd1001);
    calibrate(16'd6, 16'd1000);
    calibrate(16'd7, 16'd0);

    set_cfg(MODE_UNUSED, 16'd50);
    calibrate(16'h1234, 16'h4321);

    set_cfg(MODE_BID, 16'd0);
    preload(PT_1, 16'd100, 16'd1000);
    preload(PT_2, 16'd200, 16'd2000);
    preload(PT_3, 16'd300, 16'd3000);
    preload(PT_4, 16'd400, 16'd4000);
    preload(PT_5, 16'd500, 16'd5000);
    calibrate(16'd300, 16'd3000);   // on the zero with no band
    calibrate(16'd100, 16'd3001);
    calibrate(16'd100, 16'd900);
    calibrate(16'd150, 16'd3500);
    calibrate(16'd150, 16'd800);
    calibrate(16'd150, 16'd1500);
    calibrate(16'd350, 16'd5500);
    calibrate(16'd350, 16'd2500);
    calibrate(16'd350, 16'd4500);
    calibrate(16'd500, 16'd2000);
    calibrate(16'd500, 16'd6000);
    calibrate(16'd600, 16'd7000);   // past point 5
    set_cfg(MODE_BID, 16'd10);
    calibrate(16'd150, 16'd3000);
    calibrate(16'd150, 16'd3009);
    calibrate(16'd150, 16'd2991);
    calibrate(16'd150, 16'd2990);
    set_cfg(MODE_BID, 16'hFFFF);
    calibrate(16'd0, 16'd0);

    for (int p = 0; p < 16; p++) begin
      if (p == 7 || p == 13) mode = MODE_UNUSED;
      else case (p % 4)
        0:       mode = MODE_POS;
        1:       mode = MODE_NEG;
        default: mode = MODE_BID;
      endcase
      case (p % 5)
        0:       db = 16'd0;
        1:       db = 16'($urandom_range(1, 40));
        2:       db = 16'hFFFF;
        3:       db = 16'($urandom_range(0, 16'hFFFF));
        default: db = 16'($urandom_range(0, 400));
      endcase
      set_cfg(mode, db);
      case (p / 4)
        0:       idle_pct = 0;
        1:       idle_pct = 54;
        2:       idle_pct = 0;
        default: idle_pct = 26;
      endcase
      if ($urandom_range(0, 99) < 85) load_table($urandom_range(0, 99) < 85);
      for (int i = 0; i < 110; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          it.action      = ACT_LOAD;
          it.point_index = PIDX_W'($urandom_range(0, 7));
          it.conc_value  = nudge(loaded_conc[pick_point()], 300);
          it.adc_sample  = nudge(loaded_adc[pick_point()], 300);
        end else if (r < 13) begin
          it.action      = 1'($urandom_range(0, 1));
          it.point_index = PIDX_W'($urandom_range(0, 7));
          it.conc_value  = 16'($urandom_range(0, 16'hFFFF));
          it.adc_sample  = 16'($urandom_range(0, 16'hFFFF));
        end else begin
          it = make_reading();
        end
        issue(it);
        if (i == 60 && p % 3 == 0) settle();
      end
    end

    settle();
    repeat (5) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
